// ----- design/uart_rb_pkg.sv -----
// Shared types and constants for the UART register block.
package uart_rb_pkg;

  // Default receive FIFO depth.
  localparam int RX_DEPTH_DEFAULT = 8;

  // Entries in the result queue in front of the response channel.
  localparam int OUTQ_DEPTH = 4;

  // Operation codes.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_TXDATA = 3'd0;
  localparam logic [2:0] REG_RXDATA = 3'd1;
  localparam logic [2:0] REG_TXCTRL = 3'd2;
  localparam logic [2:0] REG_RXCTRL = 3'd3;
  localparam logic [2:0] REG_IE     = 3'd4;
  localparam logic [2:0] REG_IP     = 3'd5;
  localparam logic [2:0] REG_IC     = 3'd6;
  localparam logic [2:0] REG_DIV    = 3'd7;

  // Access sizes that mask the write data.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic [7:0]  CHAR_CR    = 8'd13;
  localparam logic [7:0]  CHAR_LF    = 8'd10;
  localparam logic [31:0] RX_EMPTY   = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  reg_index;
    logic [1:0]  access_size;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_accepted;
    logic        irq;
    logic        last;
  } rsp_t;

  // One finished request; a CR-LF item expands into two responses.
  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_crlf;
    logic        rx_accepted;
    logic        irq;
  } item_t;

endpackage

// ----- design/uart_rb_regs.sv -----
// Register file, receive FIFO and interrupt logic of the UART register block.
module uart_rb_regs #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  uart_rb_pkg::req_t   req,
  output logic                stage_valid,
  output uart_rb_pkg::item_t  stage_item
);
  import uart_rb_pkg::*;

  localparam int PTR_W = $clog2(RX_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] WM_STEP = CNT_W'(RX_DEPTH / 8);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

  logic [7:0]       mem [RX_DEPTH];
  logic [7:0]       mem_q;

  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic             tx_enable, tx_enable_next;
  logic             two_stop_bits, two_stop_bits_next;
  logic [2:0]       tx_level, tx_level_next;
  logic             rx_enable, rx_enable_next;
  logic [2:0]       rx_level, rx_level_next;
  logic [2:0]       int_enable, int_enable_next;
  logic [2:0]       int_pending, int_pending_next;
  logic [15:0]      baud_divisor, baud_divisor_next;
  logic             irq_line, irq_line_next;

  logic [PTR_W-1:0] rd_inc, wr_inc;
  logic [31:0]      wdata;
  logic [CNT_W-1:0] count_next, threshold;
  logic             pop, push, recomp;
  item_t            item;
  item_t            stage;
  logic             stage_pop;

  assign rd_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;

  always_comb begin
    unique case (req.access_size)
      SIZE_BYTE: wdata = {24'b0, req.write_value[7:0]};
      SIZE_HALF: wdata = {16'b0, req.write_value[15:0]};
      default:   wdata = req.write_value;
    endcase
  end

  always_comb begin
    rd_ptr_next        = rd_ptr;
    wr_ptr_next        = wr_ptr;
    tx_enable_next     = tx_enable;
    two_stop_bits_next = two_stop_bits;
    tx_level_next      = tx_level;
    rx_enable_next     = rx_enable;
    rx_level_next      = rx_level;
    int_enable_next    = int_enable;
    int_pending_next   = int_pending;
    baud_divisor_next  = baud_divisor;
    pop                = 1'b0;
    push               = 1'b0;
    recomp             = 1'b0;
    item               = '0;

    if (take) begin
      unique case (req.operation)
        OP_READ: begin
          recomp = 1'b1;
          unique case (req.reg_index)
            REG_TXDATA: item.read_data = '0;
            REG_RXDATA: begin
              if (rd_ptr != wr_ptr) begin
                pop         = 1'b1;
                rd_ptr_next = rd_inc;
              end else begin
                item.read_data = RX_EMPTY;
              end
            end
            REG_TXCTRL: item.read_data = {13'b0, tx_level, 14'b0, two_stop_bits, tx_enable};
            REG_RXCTRL: item.read_data = {13'b0, rx_level, 15'b0, rx_enable};
            REG_IE:     item.read_data = {29'b0, int_enable};
            REG_IP:     item.read_data = {29'b0, int_pending};
            REG_IC:     item.read_data = {29'b0, int_pending};
            REG_DIV:    item.read_data = {16'b0, baud_divisor};
          endcase
        end
        OP_WRITE: begin
          unique case (req.reg_index)
            REG_TXDATA: begin
              if (tx_enable) begin
                item.tx_valid = 1'b1;
                item.tx_byte  = wdata[7:0];
                item.tx_crlf  = (wdata[7:0] == CHAR_LF);
              end
            end
            REG_TXCTRL: begin
              tx_enable_next     = wdata[0];
              two_stop_bits_next = wdata[1];
              tx_level_next      = wdata[18:16];
            end
            REG_RXCTRL: begin
              rx_enable_next = wdata[0];
              rx_level_next  = wdata[18:16];
              recomp         = 1'b1;
            end
            REG_IE: begin
              int_enable_next = wdata[2:0];
              recomp          = 1'b1;
            end
            REG_IC:  int_pending_next = int_pending & ~{wdata[2:1], 1'b0};
            REG_DIV: baud_divisor_next = wdata[15:0];
            default: ;
          endcase
        end
        OP_RX: begin
          if (rx_enable && wr_inc != rd_ptr) begin
            push             = 1'b1;
            wr_ptr_next      = wr_inc;
            recomp           = 1'b1;
            item.rx_accepted = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Watermark and irq are refreshed only by the requests that ask for it.
    count_next = (wr_ptr_next >= rd_ptr_next)
               ? {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next}
               : {1'b0, wr_ptr_next} + CNT_W'(RX_DEPTH) - {1'b0, rd_ptr_next};
    threshold  = WM_STEP * CNT_W'(rx_level_next);
    irq_line_next = irq_line;
    if (recomp) begin
      int_pending_next[1] = (count_next > threshold);
      irq_line_next       = |(int_enable_next & int_pending_next);
    end
    item.irq = irq_line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      tx_enable     <= 1'b0;
      two_stop_bits <= 1'b0;
      tx_level      <= '0;
      rx_enable     <= 1'b0;
      rx_level      <= '0;
      int_enable    <= '0;
      int_pending   <= 3'b001;
      baud_divisor  <= '0;
      irq_line      <= 1'b0;
      stage_valid   <= 1'b0;
    end else begin
      rd_ptr        <= rd_ptr_next;
      wr_ptr        <= wr_ptr_next;
      tx_enable     <= tx_enable_next;
      two_stop_bits <= two_stop_bits_next;
      tx_level      <= tx_level_next;
      rx_enable     <= rx_enable_next;
      rx_level      <= rx_level_next;
      int_enable    <= int_enable_next;
      int_pending   <= int_pending_next;
      baud_divisor  <= baud_divisor_next;
      irq_line      <= irq_line_next;
      stage_valid   <= take;
    end
  end

  always_ff @(posedge clk) begin
    stage     <= item;
    stage_pop <= pop;
  end

  // Receive store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= req.rx_byte;
    end
    if (pop) begin
      mem_q <= mem[rd_ptr];
    end
  end

  always_comb begin
    stage_item = stage;
    if (stage_pop) begin
      stage_item.read_data = 32'(mem_q);
    end
  end

`ifndef SYNTHESIS
  a_pend_bit0: assert property (@(posedge clk) disable iff (rst) int_pending[0])
    else $error("pending bit 0 was cleared");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (rd_ptr != wr_ptr))
    else $error("receive FIFO popped while empty");
  a_irq_refresh: assert property (@(posedge clk) disable iff (rst)
    (take && recomp) |=> (irq_line == |(int_enable & int_pending)))
    else $error("irq does not match enabled pending bits after refresh");
`endif

endmodule

// ----- design/uart_rb_outq.sv -----
// Result queue that turns finished requests into responses, splitting CR-LF.
module uart_rb_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                stage_valid,
  input  uart_rb_pkg::item_t  stage_item,
  output logic                full,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output uart_rb_pkg::rsp_t   rsp
);
  import uart_rb_pkg::*;

  localparam int QP_W = $clog2(OUTQ_DEPTH);
  localparam int QC_W = $clog2(OUTQ_DEPTH + 1) + 1;
  localparam logic [QP_W-1:0] QP_LAST = QP_W'(OUTQ_DEPTH - 1);

  item_t            q [OUTQ_DEPTH];
  logic [QP_W-1:0]  head, tail;
  logic [QC_W-1:0]  count;
  logic             phase;
  item_t            hd;
  logic             first_half, pop, deq;

  assign hd         = q[head];
  assign first_half = hd.tx_crlf && !phase;
  assign rsp_valid  = (count != '0);
  assign pop        = rsp_valid && !rsp_stall;
  assign deq        = pop && !first_half;

  // Room is kept for the request in the stage and one more.
  assign full = (count + QC_W'(stage_valid)) >= QC_W'(OUTQ_DEPTH);

  always_comb begin
    rsp.read_data   = hd.read_data;
    rsp.tx_valid    = hd.tx_valid;
    rsp.tx_byte     = first_half ? CHAR_CR : hd.tx_byte;
    rsp.rx_accepted = hd.rx_accepted;
    rsp.irq         = hd.irq;
    rsp.last        = !first_half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      phase <= 1'b0;
    end else begin
      if (stage_valid) begin
        tail <= (tail == QP_LAST) ? '0 : tail + 1'b1;
      end
      if (deq) begin
        head <= (head == QP_LAST) ? '0 : head + 1'b1;
      end
      count <= count + QC_W'(stage_valid) - QC_W'(deq);
      if (pop) begin
        phase <= first_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      q[tail] <= stage_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (count < QC_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");
  a_phase_crlf: assert property (@(posedge clk) disable iff (rst)
    phase |-> (rsp_valid && hd.tx_crlf))
    else $error("second half pending without a CR-LF entry");
`endif

endmodule

// ----- design/uart_register_block_rx_fifo.sv -----
// Top level of the UART register block with receive FIFO.
//
// Requests arrive on req (valid/stall): a register read, a register write or a
// byte received from the line. Each request produces one response on rsp,
// except a transmit write of LF while transmit is enabled, which produces a CR
// response (last low) followed by the LF response (last high).
// An accepted request passes through the stage register in the register file
// and then the result queue before its first response is valid.
// One request is taken every cycle while req_stall is low; a CR-LF request
// uses two responses on the response channel. The request side runs ahead
// while responses wait in a four-entry result queue; req_stall rises once
// that queue, together with the request in flight, leaves no room for another.
// When rsp_stall is high the current response holds and the queue fills, then
// req_stall is raised. Register state is read and updated in the cycle a
// request is accepted, so back-to-back requests see each other's effects.
// Reset clears all registers and pointers, sets pending bit 0 and empties the
// queue; the receive store contents are undefined until written.
module uart_register_block_rx_fifo #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  uart_rb_pkg::req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output uart_rb_pkg::rsp_t  rsp
);
  import uart_rb_pkg::*;

  logic  take;
  logic  stage_valid;
  item_t stage_item;
  logic  full;

  assign req_stall = full;
  assign take      = req_valid && !req_stall;

  uart_rb_regs #(
    .RX_DEPTH (RX_DEPTH)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .req         (req),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  uart_rb_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .full        (full),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule
